// ===== rtl/qcsv_pkg.sv =====
// ----------------------------------------------------------------------------
// qcsv_pkg: shared types and constants for the quoted CSV record parser
// Holds the character codes, the parse phase and event encodings, the
// result word layout and the saturating digit accumulate function.
// ----------------------------------------------------------------------------
package qcsv_pkg;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_COMMA = 8'h2C;
  localparam logic [7:0]  CHAR_QUOTE = 8'h22;
  localparam logic [7:0]  CHAR_PAREN = 8'h28;
  localparam logic [30:0] SAT_MAX    = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_LINENUM  = 4'd1,
    PH_OPENCITY = 4'd2,
    PH_CITY     = 4'd3,
    PH_COMMA2   = 4'd4,
    PH_POPSEL   = 4'd5,
    PH_POP      = 4'd6,
    PH_DONE     = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CITY   = 2'd1,
    EV_RECORD = 2'd2,
    EV_ERROR  = 2'd3
  } event_t;

  typedef struct packed {
    event_t      event_kind;
    logic [7:0]  city_char;
    logic [30:0] line_number;
    logic [30:0] population;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

  // acc * 10 + digit, saturating. The multiply by ten is two shifted adds.
  function automatic logic [30:0] acc_digit(input logic [30:0] acc,
                                            input logic [7:0]  b);
    logic [34:0] v;
    logic [7:0]  d;
    d = b - CHAR_ZERO;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, d[3:0]};
    if (v > {4'b0, SAT_MAX}) begin
      return SAT_MAX;
    end
    return v[30:0];
  endfunction

endpackage

// ===== rtl/quoted_csv_record_parser.sv =====
// An accepted word's result is registered into the output register, or into the
// skid register if the output is held. One word per cycle while in_ready is high.
// A two-entry result buffer (output register plus skid register) lets the
// input keep accepting while one result waits; in_ready falls only when both are full.
// Reset (synchronous, rst_n low) returns the parser to the start phase, clears
// both accumulators and empties the result buffer.
// ----------------------------------------------------------------------------
// quoted_csv_record_parser: byte-serial parser for quoted CSV city records
// Each line holds a line number, a quoted city name and either a quoted
// population (digits optionally grouped by commas) or '(' for zero. City
// bytes are passed on as they arrive; the record is emitted at its end.
// ----------------------------------------------------------------------------
module quoted_csv_record_parser
  import qcsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_line_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_city_char,
  output logic [30:0] out_line_number,
  output logic [30:0] out_population
);

  // Parser state.
  phase_t      phase_r,  phase_nxt;
  logic [30:0] lacc_r,   lacc_nxt;
  logic [30:0] pacc_r,   pacc_nxt;

  // Result buffer: the output register and a skid register behind it.
  result_t     out_r,    out_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     skid_r,   skid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  // Working values after a line start has been applied.
  phase_t      ph_base;
  logic [30:0] lacc_base;
  logic [30:0] pacc_base;
  result_t     res;
  logic        in_fire;
  logic        out_fire;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // A line start puts the parser back at the start before the byte is used.
  assign ph_base   = in_line_start ? PH_START : phase_r;
  assign lacc_base = in_line_start ? '0 : lacc_r;
  assign pacc_base = in_line_start ? '0 : pacc_r;

  // Next state of the parser and its accumulators.
  always_comb begin
    phase_nxt = ph_base;
    lacc_nxt  = lacc_base;
    pacc_nxt  = pacc_base;
    case (ph_base)
      PH_START: begin
        if (is_digit(in_text_byte)) begin
          lacc_nxt  = acc_digit('0, in_text_byte);
          phase_nxt = PH_LINENUM;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_LINENUM: begin
        if (is_digit(in_text_byte)) begin
          lacc_nxt = acc_digit(lacc_base, in_text_byte);
        end else if (in_text_byte == CHAR_COMMA) begin
          phase_nxt = PH_OPENCITY;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_OPENCITY: begin
        phase_nxt = (in_text_byte == CHAR_QUOTE) ? PH_CITY : PH_ERROR;
      end
      PH_CITY: begin
        if (in_text_byte == CHAR_QUOTE) begin
          phase_nxt = PH_COMMA2;
        end
      end
      PH_COMMA2: begin
        phase_nxt = (in_text_byte == CHAR_COMMA) ? PH_POPSEL : PH_ERROR;
      end
      PH_POPSEL: begin
        if (in_text_byte == CHAR_QUOTE) begin
          pacc_nxt  = '0;
          phase_nxt = PH_POP;
        end else if (in_text_byte == CHAR_PAREN) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_POP: begin
        // Commas inside the quoted population only group digits.
        if (is_digit(in_text_byte)) begin
          pacc_nxt = acc_digit(pacc_base, in_text_byte);
        end else if (in_text_byte == CHAR_QUOTE) begin
          phase_nxt = PH_DONE;
        end else if (in_text_byte != CHAR_COMMA) begin
          phase_nxt = PH_ERROR;
        end
      end
      default: begin
        // Done or error: the rest of the line is ignored.
      end
    endcase
  end

  // Result word for the byte being accepted.
  always_comb begin
    res            = '0;
    res.event_kind = EV_NONE;
    case (ph_base)
      PH_START: begin
        if (!is_digit(in_text_byte)) begin
          res.event_kind = EV_ERROR;
        end
      end
      PH_LINENUM: begin
        if (!is_digit(in_text_byte) && in_text_byte != CHAR_COMMA) begin
          res.event_kind = EV_ERROR;
        end
      end
      PH_OPENCITY: begin
        if (in_text_byte != CHAR_QUOTE) begin
          res.event_kind = EV_ERROR;
        end
      end
      PH_CITY: begin
        if (in_text_byte != CHAR_QUOTE) begin
          res.event_kind = EV_CITY;
          res.city_char  = in_text_byte;
        end
      end
      PH_COMMA2: begin
        if (in_text_byte != CHAR_COMMA) begin
          res.event_kind = EV_ERROR;
        end
      end
      PH_POPSEL: begin
        if (in_text_byte == CHAR_PAREN) begin
          res.event_kind  = EV_RECORD;
          res.line_number = lacc_base;
        end else if (in_text_byte != CHAR_QUOTE) begin
          res.event_kind = EV_ERROR;
        end
      end
      PH_POP: begin
        if (in_text_byte == CHAR_QUOTE) begin
          res.event_kind  = EV_RECORD;
          res.line_number = lacc_base;
          res.population  = pacc_base;
        end else if (!is_digit(in_text_byte) && in_text_byte != CHAR_COMMA) begin
          res.event_kind = EV_ERROR;
        end
      end
      default: begin
        res.event_kind = EV_NONE;
      end
    endcase
  end

  // Result buffer steering. While the skid register holds a word, in_ready
  // is low, so a new result only ever lands in an empty slot.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      lacc_r       <= '0;
      pacc_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        lacc_r  <= lacc_nxt;
        pacc_r  <= pacc_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_r.event_kind;
  assign out_city_char   = out_r.city_char;
  assign out_line_number = out_r.line_number;
  assign out_population  = out_r.population;

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output is empty");

  // Numbers are only reported with a record.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.event_kind != EV_RECORD) |->
      (out_r.line_number == '0 && out_r.population == '0))
    else $error("line number or population set outside a record");

  // Once in the error phase, only a line start leaves it.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR && !(in_fire && in_line_start)) |=> phase_r == PH_ERROR)
    else $error("parser left the error phase without a line start");

  // A finished record holds the parser until the next line start.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !(in_fire && in_line_start)) |=> phase_r == PH_DONE)
    else $error("parser left the done phase without a line start");

endmodule
